### design/sps_pkg.sv
// Shared types, constants and helper functions for spectrum_phase_shift_polar.
// Used by every module of the block; depends on nothing.
package sps_pkg;

    // Field widths
    localparam int DATA_WIDTH      = 24;
    localparam int PHASE_WIDTH_DEF = 32;
    localparam int BIN_W           = 16;
    localparam int OUT_W           = DATA_WIDTH + 2;
    localparam int GUARD           = 32 - DATA_WIDTH;

    // Datapath widths: CORDIC x/y, rotation angle, vectoring angle
    localparam int CW     = 36;
    localparam int ZW     = 33;
    localparam int AW     = 32;
    localparam int STAGES = 28;

    // 1/K in 2.30 format, positive
    localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

    // Register indexes
    localparam logic REG_OUTPUT_KIND = 1'b0;
    localparam logic REG_PHASE_STEP  = 1'b1;

    // Output selections
    localparam logic [1:0] KIND_AMP   = 2'd0;
    localparam logic [1:0] KIND_PHASE = 2'd1;
    localparam logic [1:0] KIND_REAL  = 2'd2;
    localparam logic [1:0] KIND_IMAG  = 2'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] real_part;
        logic signed [DATA_WIDTH-1:0] imag_part;
        logic        [BIN_W-1:0]      bin_index;
        logic                         last_bin;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    last_out;
    } out_t;

    // atan(2^-i) in turns * 2^32
    function automatic logic [AW-1:0] atan_turns(input int unsigned i);
        logic [AW-1:0] r;
        begin
            case (i)
                0:       r = 32'd536870912;
                1:       r = 32'd316933406;
                2:       r = 32'd167458907;
                3:       r = 32'd85004756;
                4:       r = 32'd42667331;
                5:       r = 32'd21354465;
                6:       r = 32'd10679838;
                7:       r = 32'd5340245;
                8:       r = 32'd2670163;
                9:       r = 32'd1335087;
                10:      r = 32'd667544;
                11:      r = 32'd333772;
                12:      r = 32'd166886;
                13:      r = 32'd83443;
                14:      r = 32'd41722;
                15:      r = 32'd20861;
                16:      r = 32'd10430;
                17:      r = 32'd5215;
                18:      r = 32'd2608;
                19:      r = 32'd1304;
                20:      r = 32'd652;
                21:      r = 32'd326;
                22:      r = 32'd163;
                23:      r = 32'd81;
                24:      r = 32'd41;
                25:      r = 32'd20;
                26:      r = 32'd10;
                27:      r = 32'd5;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // Round half up, then arithmetic shift right; s is a constant at every call
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input int unsigned s);
        logic signed [63:0] bias;
        begin
            bias = 64'sd1 <<< (s - 1);
            return (v + bias) >>> s;
        end
    endfunction

    // Clamp to the signed output range
    function automatic logic signed [OUT_W-1:0] sat(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            hi = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            if (v > hi)
                return hi[OUT_W-1:0];
            else if (v < lo)
                return lo[OUT_W-1:0];
            else
                return v[OUT_W-1:0];
        end
    endfunction

endpackage

### design/sps_gain.sv
// Two-stage 1/K gain multiplier, one lane per operand, split into partial products.
// Depends on sps_pkg.
module sps_gain #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [sps_pkg::CW-1:0]   a [LANES],
    input  logic        [SIDE_W-1:0]        side_in,
    output logic                            out_valid,
    output logic signed [63:0]              prod [LANES],
    output logic        [SIDE_W-1:0]        side_out
);

    localparam int LO_W = sps_pkg::CW / 2;
    localparam int HI_W = sps_pkg::CW - LO_W;

    logic                     v1_reg;
    logic                     v2_reg;
    logic [SIDE_W-1:0]        side1_reg;
    logic [SIDE_W-1:0]        side2_reg;
    logic signed [HI_W+31:0]  pp_hi_reg [LANES];
    logic signed [LO_W+32:0]  pp_lo_reg [LANES];
    logic signed [63:0]       sum_reg   [LANES];

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side_in;
        side2_reg <= side1_reg;
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [HI_W-1:0]   a_hi;
        logic signed [LO_W:0]     a_lo;
        logic signed [HI_W+31:0]  pp_hi_next;
        logic signed [LO_W+32:0]  pp_lo_next;
        logic signed [63:0]       sum_next;

        // Partial products: signed high half, unsigned low half
        always_comb
        begin
            a_hi       = a[l][sps_pkg::CW-1:LO_W];
            a_lo       = $signed({1'b0, a[l][LO_W-1:0]});
            pp_hi_next = a_hi * sps_pkg::INV_GAIN;
            pp_lo_next = a_lo * sps_pkg::INV_GAIN;
            sum_next   = ($signed(64'(pp_hi_reg[l])) <<< LO_W) + $signed(64'(pp_lo_reg[l]));
        end

        always_ff @(posedge clk)
        begin
            pp_hi_reg[l] <= pp_hi_next;
            pp_lo_reg[l] <= pp_lo_next;
            sum_reg[l]   <= sum_next;
        end

        assign prod[l] = sum_reg[l];
    end

    assign out_valid = v2_reg;
    assign side_out  = side2_reg;

endmodule

### design/sps_rotate.sv
// Pipelined CORDIC in rotation mode, one micro-rotation per register stage.
// Depends on sps_pkg.
module sps_rotate #(
    parameter int SIDE_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [sps_pkg::CW-1:0]   x_in,
    input  logic signed [sps_pkg::CW-1:0]   y_in,
    input  logic signed [sps_pkg::ZW-1:0]   z_in,
    input  logic        [SIDE_W-1:0]        side_in,
    output logic                            out_valid,
    output logic signed [sps_pkg::CW-1:0]   x_out,
    output logic signed [sps_pkg::CW-1:0]   y_out,
    output logic        [SIDE_W-1:0]        side_out
);

    localparam int N = sps_pkg::STAGES;

    logic                           v_reg    [N];
    logic signed [sps_pkg::CW-1:0]  x_reg    [N];
    logic signed [sps_pkg::CW-1:0]  y_reg    [N];
    logic signed [sps_pkg::ZW-1:0]  z_reg    [N];
    logic        [SIDE_W-1:0]       side_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic                           v_prev;
        logic signed [sps_pkg::CW-1:0]  x_prev;
        logic signed [sps_pkg::CW-1:0]  y_prev;
        logic signed [sps_pkg::ZW-1:0]  z_prev;
        logic        [SIDE_W-1:0]       side_prev;
        logic signed [sps_pkg::CW-1:0]  x_next;
        logic signed [sps_pkg::CW-1:0]  y_next;
        logic signed [sps_pkg::ZW-1:0]  z_next;
        logic signed [sps_pkg::ZW-1:0]  step;

        if (i == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign x_prev    = x_in;
            assign y_prev    = y_in;
            assign z_prev    = z_in;
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[i-1];
            assign x_prev    = x_reg[i-1];
            assign y_prev    = y_reg[i-1];
            assign z_prev    = z_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // Turn toward zero residual angle
        always_comb
        begin
            step = $signed({1'b0, sps_pkg::atan_turns(i)});
            if (!z_prev[sps_pkg::ZW-1])
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                z_next = z_prev - step;
            end
            else
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                z_next = z_prev + step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            x_reg[i]    <= x_next;
            y_reg[i]    <= y_next;
            z_reg[i]    <= z_next;
            side_reg[i] <= side_prev;
        end
    end

    assign out_valid = v_reg[N-1];
    assign x_out     = x_reg[N-1];
    assign y_out     = y_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

### design/sps_vector.sv
// Pipelined CORDIC in vectoring mode: magnitude and angle, one step per stage.
// Depends on sps_pkg.
module sps_vector #(
    parameter int SIDE_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [sps_pkg::CW-1:0]   x_in,
    input  logic signed [sps_pkg::CW-1:0]   y_in,
    input  logic        [SIDE_W-1:0]        side_in,
    output logic                            out_valid,
    output logic signed [sps_pkg::CW-1:0]   mag_out,
    output logic        [sps_pkg::AW-1:0]   ang_out,
    output logic        [SIDE_W-1:0]        side_out
);

    localparam int N = sps_pkg::STAGES;

    logic                           v_reg    [N];
    logic signed [sps_pkg::CW-1:0]  x_reg    [N];
    logic signed [sps_pkg::CW-1:0]  y_reg    [N];
    logic        [sps_pkg::AW-1:0]  a_reg    [N];
    logic        [SIDE_W-1:0]       side_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic                           v_prev;
        logic signed [sps_pkg::CW-1:0]  x_prev;
        logic signed [sps_pkg::CW-1:0]  y_prev;
        logic        [sps_pkg::AW-1:0]  a_prev;
        logic        [SIDE_W-1:0]       side_prev;
        logic signed [sps_pkg::CW-1:0]  x_next;
        logic signed [sps_pkg::CW-1:0]  y_next;
        logic        [sps_pkg::AW-1:0]  a_next;

        if (i == 0)
        begin : g_first
            // Fold the left half plane over by a half turn
            always_comb
            begin
                v_prev    = in_valid;
                side_prev = side_in;
                if (x_in[sps_pkg::CW-1])
                begin
                    x_prev = -x_in;
                    y_prev = -y_in;
                    a_prev = {1'b1, {(sps_pkg::AW-1){1'b0}}};
                end
                else
                begin
                    x_prev = x_in;
                    y_prev = y_in;
                    a_prev = '0;
                end
            end
        end
        else
        begin : g_next
            assign v_prev    = v_reg[i-1];
            assign x_prev    = x_reg[i-1];
            assign y_prev    = y_reg[i-1];
            assign a_prev    = a_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // Drive y toward zero, accumulate angle modulo one turn
        always_comb
        begin
            if (!y_prev[sps_pkg::CW-1])
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                a_next = a_prev + sps_pkg::atan_turns(i);
            end
            else
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                a_next = a_prev - sps_pkg::atan_turns(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            x_reg[i]    <= x_next;
            y_reg[i]    <= y_next;
            a_reg[i]    <= a_next;
            side_reg[i] <= side_prev;
        end
    end

    assign out_valid = v_reg[N-1];
    assign mag_out   = x_reg[N-1];
    assign ang_out   = a_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

### design/spectrum_phase_shift_polar.sv
// Pipeline: five single register stages (input, bin angle, quadrant, rounding and
// output), two 28-stage CORDIC pipelines and two 2-stage gain multipliers lie between
// the edge that takes start and the result strobe (done).
// Throughput: one bin per cycle, busy is always low; the receiver cannot stall.
// Reset: asynchronous, active low; clears all valid bits, output_kind and phase_step.
// Depends on sps_pkg, sps_rotate, sps_vector, sps_gain.
module spectrum_phase_shift_polar #(
    parameter int PHASE_WIDTH = sps_pkg::PHASE_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sps_pkg::in_t    din,
    output logic            done,
    output sps_pkg::out_t   dout,
    input  logic            wr_en,
    input  logic            wr_index,
    input  logic [31:0]     wr_data
);

    localparam int CW    = sps_pkg::CW;
    localparam int ZW    = sps_pkg::ZW;
    localparam int AW    = sps_pkg::AW;
    localparam int DW    = sps_pkg::DATA_WIDTH;
    localparam int OW    = sps_pkg::OUT_W;
    localparam int G     = sps_pkg::GUARD;
    localparam int VSIDE = 2 + 2 * OW;

    // Configuration registers
    logic [1:0]  kind_reg;
    logic [31:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= sps_pkg::KIND_AMP;
            step_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sps_pkg::REG_OUTPUT_KIND: kind_reg <= wr_data[1:0];
                sps_pkg::REG_PHASE_STEP:  step_reg <= wr_data;
                default:                  ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: input register
    logic          in_v_reg;
    sps_pkg::in_t  in_reg;

    // Stage 2: bin angle
    logic                    th_v_reg;
    sps_pkg::in_t            th_item_reg;
    logic [PHASE_WIDTH-1:0]  theta_reg;
    logic [47:0]             theta_prod;

    // Stage 3: quadrant and residual
    logic                  pr_v_reg;
    logic                  pr_last_reg;
    logic signed [CW-1:0]  pr_x_reg;
    logic signed [CW-1:0]  pr_y_reg;
    logic signed [ZW-1:0]  pr_z_reg;
    logic signed [CW-1:0]  pr_x_next;
    logic signed [CW-1:0]  pr_y_next;
    logic signed [ZW-1:0]  pr_z_next;
    logic [AW-1:0]         theta_full;
    logic [AW-1:0]         phi;
    logic [AW-1:0]         q_sum;
    logic [1:0]            quad;
    logic [AW-1:0]         resid;
    logic signed [CW-1:0]  xi;
    logic signed [CW-1:0]  yi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            th_v_reg <= 1'b0;
            pr_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
            th_v_reg <= in_v_reg;
            pr_v_reg <= th_v_reg;
        end
    end

    assign theta_prod = 48'(in_reg.bin_index) * 48'(step_reg);

    // Split rotation -theta into an exact quarter turn and a CORDIC residual
    always_comb
    begin
        theta_full = AW'(theta_reg) << (AW - PHASE_WIDTH);
        phi        = -theta_full;
        q_sum      = phi + 32'h2000_0000;
        quad       = q_sum[AW-1:AW-2];
        resid      = phi - {quad, {(AW-2){1'b0}}};
        pr_z_next  = $signed({resid[AW-1], resid});
        xi         = CW'($signed({th_item_reg.real_part, {G{1'b0}}}));
        yi         = CW'($signed({th_item_reg.imag_part, {G{1'b0}}}));
        case (quad)
            2'd1:
            begin
                pr_x_next = -yi;
                pr_y_next = xi;
            end
            2'd2:
            begin
                pr_x_next = -xi;
                pr_y_next = -yi;
            end
            2'd3:
            begin
                pr_x_next = yi;
                pr_y_next = -xi;
            end
            default:
            begin
                pr_x_next = xi;
                pr_y_next = yi;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= din;
        th_item_reg <= in_reg;
        theta_reg   <= theta_prod[31:32-PHASE_WIDTH];
        pr_x_reg    <= pr_x_next;
        pr_y_reg    <= pr_y_next;
        pr_z_reg    <= pr_z_next;
        pr_last_reg <= th_item_reg.last_bin;
    end

    // Rotation CORDIC
    logic                  rot_v;
    logic signed [CW-1:0]  rot_x;
    logic signed [CW-1:0]  rot_y;
    logic                  rot_last;

    sps_rotate #(
        .SIDE_W (1)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pr_v_reg),
        .x_in      (pr_x_reg),
        .y_in      (pr_y_reg),
        .z_in      (pr_z_reg),
        .side_in   (pr_last_reg),
        .out_valid (rot_v),
        .x_out     (rot_x),
        .y_out     (rot_y),
        .side_out  (rot_last)
    );

    // Gain correction of the rotated vector
    logic signed [CW-1:0]  rg_a    [2];
    logic signed [63:0]    rg_prod [2];
    logic                  rg_v;
    logic                  rg_last;

    assign rg_a[0] = rot_x;
    assign rg_a[1] = rot_y;

    sps_gain #(
        .LANES  (2),
        .SIDE_W (1)
    ) u_rot_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_v),
        .a         (rg_a),
        .side_in   (rot_last),
        .out_valid (rg_v),
        .prod      (rg_prod),
        .side_out  (rg_last)
    );

    // Rounding stage: corrected vector with guard bits, and final real/imag
    logic                  rd_v_reg;
    logic signed [CW-1:0]  rd_cx_reg;
    logic signed [CW-1:0]  rd_cy_reg;
    logic [VSIDE-1:0]      rd_side_reg;
    logic signed [63:0]    cx_full;
    logic signed [63:0]    cy_full;
    logic [VSIDE-1:0]      rd_side_next;

    always_comb
    begin
        cx_full      = sps_pkg::rnd(rg_prod[0], 30);
        cy_full      = sps_pkg::rnd(rg_prod[1], 30);
        rd_side_next = {rg_last,
                        (cx_full == 64'sd0) && (cy_full == 64'sd0),
                        sps_pkg::sat(sps_pkg::rnd(rg_prod[0], 30 + G)),
                        sps_pkg::sat(sps_pkg::rnd(rg_prod[1], 30 + G))};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_v_reg <= 1'b0;
        else
            rd_v_reg <= rg_v;
    end

    always_ff @(posedge clk)
    begin
        rd_cx_reg   <= cx_full[CW-1:0];
        rd_cy_reg   <= cy_full[CW-1:0];
        rd_side_reg <= rd_side_next;
    end

    // Vectoring CORDIC
    logic                  vec_v;
    logic signed [CW-1:0]  vec_mag;
    logic [AW-1:0]         vec_ang;
    logic [VSIDE-1:0]      vec_side;

    sps_vector #(
        .SIDE_W (VSIDE)
    ) u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_v_reg),
        .x_in      (rd_cx_reg),
        .y_in      (rd_cy_reg),
        .side_in   (rd_side_reg),
        .out_valid (vec_v),
        .mag_out   (vec_mag),
        .ang_out   (vec_ang),
        .side_out  (vec_side)
    );

    // Gain correction of the magnitude
    logic signed [CW-1:0]  ag_a    [1];
    logic signed [63:0]    ag_prod [1];
    logic                  ag_v;
    logic [AW+VSIDE-1:0]   ag_side;

    assign ag_a[0] = vec_mag;

    sps_gain #(
        .LANES  (1),
        .SIDE_W (AW + VSIDE)
    ) u_amp_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_v),
        .a         (ag_a),
        .side_in   ({vec_ang, vec_side}),
        .out_valid (ag_v),
        .prod      (ag_prod),
        .side_out  (ag_side)
    );

    // Output select
    logic [AW-1:0]          fin_ang;
    logic                   fin_last;
    logic                   fin_zero;
    logic signed [OW-1:0]   fin_real;
    logic signed [OW-1:0]   fin_imag;
    logic [AW:0]            ph_sum;
    logic signed [DW-1:0]   ph_raw;
    logic signed [OW-1:0]   ph_val;
    logic signed [OW-1:0]   value_next;
    logic                   done_reg;
    sps_pkg::out_t          dout_reg;

    always_comb
    begin
        {fin_ang, fin_last, fin_zero, fin_real, fin_imag} = ag_side;
        ph_sum = {1'b0, fin_ang} + ((AW + 1)'(1) << (G - 1));
        ph_raw = $signed(ph_sum[G+DW-1:G]);
        // Minus pi folds to plus pi; zero vector has no angle
        if (fin_zero)
            ph_val = '0;
        else if (ph_raw == $signed({1'b1, {(DW-1){1'b0}}}))
            ph_val = OW'(-(OW'(ph_raw)));
        else
            ph_val = OW'(ph_raw);
        case (kind_reg)
            sps_pkg::KIND_AMP:   value_next = sps_pkg::sat(sps_pkg::rnd(ag_prod[0], 30 + G));
            sps_pkg::KIND_PHASE: value_next = ph_val;
            sps_pkg::KIND_REAL:  value_next = fin_real;
            sps_pkg::KIND_IMAG:  value_next = fin_imag;
            default:             value_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ag_v;
    end

    always_ff @(posedge clk)
    begin
        dout_reg.value    <= value_next;
        dout_reg.last_out <= fin_last;
    end

    assign done = done_reg;
    assign dout = dout_reg;

`ifndef NO_ASSERTIONS
    // Every accepted bin raises the result strobe (done)
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##65 done)
        else $error("result strobe missing after fixed latency");

    // No result without a matching transfer in
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 65))
        else $error("result strobe without accepted bin");

    // Phase lies in (-pi, pi]
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind_reg == sps_pkg::KIND_PHASE) |->
        (dout.value <= (OW'(1) <<< (DW - 1)) && dout.value > -(OW'(1) <<< (DW - 1))))
        else $error("phase out of range");

    // Amplitude is never negative
    a_amp_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind_reg == sps_pkg::KIND_AMP) |-> !dout.value[OW-1])
        else $error("negative amplitude");
`endif

endmodule
